### rtl/bezier_curve_evaluator_core_macros.svh
// Assertion helpers for the evaluator core, which checks its own logic.
`ifndef BEZIER_CURVE_EVALUATOR_CORE_MACROS_SVH
`define BEZIER_CURVE_EVALUATOR_CORE_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define BCE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("check failed: label");

// Next-cycle implication, checked on every clock edge outside reset.
`define BCE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("check failed: label");

`endif

### rtl/bce_pkg.sv
`timescale 1ns / 1ps
package bce_pkg;

   localparam int MAX_POINTS  = 16;
   localparam int MAX_SAMPLES = 64;

   localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
   localparam logic [16:0] ONE_Q16 = 17'h1_0000;

   typedef enum logic [1:0] {
      CMD_WRITE  = 2'd0,
      CMD_POINT  = 2'd1,
      CMD_DERIV  = 2'd2,
      CMD_SAMPLE = 2'd3
   } cmd_type;

   typedef enum logic [15:0] {
      ST_IDLE = 16'h0001,
      ST_DIV  = 16'h0002,
      ST_PU   = 16'h0004,
      ST_PUW  = 16'h0008,
      ST_PV   = 16'h0010,
      ST_PVW  = 16'h0020,
      ST_WA   = 16'h0040,
      ST_WB   = 16'h0080,
      ST_WC   = 16'h0100,
      ST_WD   = 16'h0200,
      ST_MX   = 16'h0400,
      ST_MY   = 16'h0800,
      ST_AY   = 16'h1000,
      ST_SCL  = 16'h2000,
      ST_RND  = 16'h4000,
      ST_FIN  = 16'h8000
   } state_type;

   typedef struct packed {
      logic        done;
      logic [16:0] quotient;
      logic [6:0]  remainder;
   } div_status_type;

   typedef logic [15:0][15:0][12:0] binom_table_type;

   // Pascal triangle, built at elaboration only.
   function automatic binom_table_type binom_table();
      binom_table_type tbl;
      tbl = '0;
      for (int n = 0; n < 16; n++) begin
         tbl[n][0] = 13'd1;
         for (int k = 1; k <= n; k++) begin
            tbl[n][k] = tbl[n-1][k-1] + ((k < n) ? tbl[n-1][k] : 13'd0);
         end
      end
      return tbl;
   endfunction

   localparam binom_table_type BINOM = binom_table();

endpackage

### rtl/bce_mul.sv
`timescale 1ns / 1ps
module bce_mul (
   input  logic        clock,
   input  logic [32:0] op_a,
   input  logic [30:0] op_b,
   output logic [63:0] prod_ff
);
   logic [63:0] prod_in;

   assign prod_in = {31'd0, op_a} * {33'd0, op_b};

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end
endmodule

### rtl/bce_div.sv
`timescale 1ns / 1ps
module bce_div (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [6:0]              divisor,
   output bce_pkg::div_status_type status
);
   import bce_pkg::*;

   logic [7:0]  rem_ff, rem_in;
   logic [17:0] quo_ff, quo_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [7:0]  shifted;
   logic        fits;

   // Restoring division of 2^17 by the divisor, one quotient bit a cycle.
   assign shifted = {rem_ff[6:0], quo_ff[17]};
   assign fits    = shifted >= {1'b0, divisor};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = 18'h2_0000;
         cnt_in  = 5'd18;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? (shifted - {1'b0, divisor}) : shifted;
         quo_in = {quo_ff[16:0], fits};
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign status.done      = done_ff;
   assign status.quotient  = quo_ff[16:0];
   assign status.remainder = rem_ff[6:0];
endmodule

### rtl/bce_store.sv
`timescale 1ns / 1ps
module bce_store (
   input  logic        clock,
   input  logic        wr_en,
   input  logic [3:0]  wr_addr,
   input  logic [31:0] wr_x,
   input  logic [31:0] wr_y,
   input  logic [3:0]  rd_addr,
   output logic [31:0] xa_ff,
   output logic [31:0] xb_ff,
   output logic [31:0] ya_ff,
   output logic [31:0] yb_ff
);
   import bce_pkg::*;

   logic [31:0] mem_x [MAX_POINTS];
   logic [31:0] mem_y [MAX_POINTS];
   logic [3:0]  rd_next;

   assign rd_next = rd_addr + 4'd1;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_x[wr_addr] <= wr_x;
         mem_y[wr_addr] <= wr_y;
      end
      xa_ff <= mem_x[rd_addr];
      xb_ff <= mem_x[rd_next];
      ya_ff <= mem_y[rd_addr];
      yb_ff <= mem_y[rd_next];
   end
endmodule

### rtl/bezier_curve_evaluator_core.sv
// Bezier curve evaluator: one shared 33x31 multiplier under a sequencer.
// A point or derivative builds the powers of u and 1-u for basis degree m, then
// weights, sums, scales and rounds; the multiplier serves the power, weight and term steps.
// A sample run first runs the divider once, then one such evaluation per sample.
// Reset (synchronous, active high) sets num_points to 4 and idles the sequencer;
// the control point store is not cleared.
`timescale 1ns / 1ps
`include "bezier_curve_evaluator_core_macros.svh"
module bezier_curve_evaluator_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // point_index[3:0], point_x[35:4], point_y[67:36], param_u[84:68],
   // sample_count[91:85], zero fill above
   input  logic [95:0] req_tdata,
   // cmd[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // out_x[31:0], out_y[63:32], sample_index[69:64], zero fill above
   output logic [71:0] rsp_tdata,
   output logic        rsp_tlast,
   input  logic        csr_wr_en,
   input  logic [4:0]  csr_wr_data
);
   import bce_pkg::*;

   state_type   state_ff, state_in;
   cmd_type     cmd_ff, cmd_in, req_cmd;
   logic [4:0]  np_ff, np_in;
   logic [16:0] u_ff, u_in;
   logic [3:0]  m_ff, m_in, nmul_ff, nmul_in;
   logic [3:0]  i_ff, i_in, k_ff, k_in;
   logic [30:0] pu_last_ff, pu_last_in, pv_last_ff, pv_last_in;
   logic [30:0] pow_u [MAX_POINTS];
   logic [30:0] pow_v [MAX_POINTS];
   logic        pu_we, pv_we, pow_init;
   logic [30:0] pp_ff, pp_in, w_ff, w_in;
   logic [32:0] ax_ff, ax_in, ay_ff, ay_in;
   logic        sx_ff, sx_in, sy_ff, sy_in;
   logic signed [55:0] sum_x_ff, sum_x_in, sum_y_ff, sum_y_in;
   logic signed [59:0] scl_x_ff, scl_x_in, scl_y_ff, scl_y_in;
   logic [1:0]  sc_ff, sc_in;
   logic signed [44:0] rnd_x_ff, rnd_x_in, rnd_y_ff, rnd_y_in;
   logic [5:0]  j_ff, j_in, d_ff, d_in;
   logic [16:0] q_ff, q_in;
   logic [6:0]  r_ff, r_in;
   // Remainder step of the sample spacing, latched from the divider.
   logic [6:0]  rstep_ff, rstep_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] out_x_ff, out_x_in, out_y_ff, out_y_in;
   logic [5:0]  idx_ff, idx_in;
   logic        last_ff, last_in;

   logic [32:0] op_a;
   logic [30:0] op_b;
   logic [63:0] prod;
   logic        div_start;
   div_status_type div_st;
   logic [31:0] xa, xb, ya, yb;
   logic        accept, store_we;
   logic [4:0]  np_clamped;
   logic [6:0]  cnt_raw, cnt_clamped;
   logic [16:0] u_raw, v_cur;
   logic signed [32:0] dx, dy;
   logic [49:0] term_mag;
   logic signed [55:0] term_s;
   logic [59:0] mag_x, mag_y;
   logic [43:0] rr_x, rr_y;
   logic        emit;
   logic [7:0]  r_sum;

   bce_mul u_mul (.clock(clock), .op_a(op_a), .op_b(op_b), .prod_ff(prod));

   bce_div u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .divisor({d_ff, 1'b0}), .status(div_st)
   );

   assign accept   = req_tvalid && req_tready;
   assign req_cmd  = cmd_type'(req_tuser);
   assign store_we = accept && (req_cmd == CMD_WRITE);

   bce_store u_store (
      .clock(clock), .wr_en(store_we), .wr_addr(req_tdata[3:0]),
      .wr_x(req_tdata[35:4]), .wr_y(req_tdata[67:36]), .rd_addr(i_ff),
      .xa_ff(xa), .xb_ff(xb), .ya_ff(ya), .yb_ff(yb)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, idx_ff, out_y_ff, out_x_ff};
   assign rsp_tlast  = last_ff;

   assign np_clamped  = (np_ff < 5'd2) ? 5'd2 : (np_ff > 5'd16) ? 5'd16 : np_ff;
   assign cnt_raw     = req_tdata[91:85];
   assign cnt_clamped = (cnt_raw < 7'd2) ? 7'd2 : (cnt_raw > 7'd64) ? 7'd64 : cnt_raw;
   assign u_raw       = req_tdata[84:68];
   assign v_cur       = ONE_Q16 - u_ff;

   assign dx = (cmd_ff == CMD_DERIV) ? ($signed({xb[31], xb}) - $signed({xa[31], xa}))
                                     : $signed({xa[31], xa});
   assign dy = (cmd_ff == CMD_DERIV) ? ($signed({yb[31], yb}) - $signed({ya[31], ya}))
                                     : $signed({ya[31], ya});

   assign term_mag = 50'((prod + 64'd8192) >> 14);
   assign mag_x    = scl_x_ff[59] ? 60'(-scl_x_ff) : 60'(scl_x_ff);
   assign mag_y    = scl_y_ff[59] ? 60'(-scl_y_ff) : 60'(scl_y_ff);
   assign rr_x     = 44'((mag_x + 60'd32768) >> 16);
   assign rr_y     = 44'((mag_y + 60'd32768) >> 16);
   assign r_sum    = {1'b0, r_ff} + {1'b0, rstep_ff};

   always_comb begin
      op_a = '0;
      op_b = '0;
      case (state_ff)
         ST_PU:   begin op_a = {2'b00, pu_last_ff}; op_b = {14'd0, u_ff};   end
         ST_PV:   begin op_a = {2'b00, pv_last_ff}; op_b = {14'd0, v_cur};  end
         ST_WA:   begin op_a = {2'b00, pow_u[i_ff]}; op_b = pow_v[m_ff - i_ff]; end
         ST_WC:   begin op_a = {2'b00, pp_ff}; op_b = {18'd0, BINOM[m_ff][i_ff]}; end
         ST_MX:   begin op_a = ax_ff; op_b = w_ff; end
         ST_MY:   begin op_a = ay_ff; op_b = w_ff; end
         default: begin op_a = '0; op_b = '0; end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      np_in        = csr_wr_en ? csr_wr_data : np_ff;
      u_in         = u_ff;
      m_in         = m_ff;
      nmul_in      = nmul_ff;
      i_in         = i_ff;
      k_in         = k_ff;
      pu_last_in   = pu_last_ff;
      pv_last_in   = pv_last_ff;
      pu_we        = 1'b0;
      pv_we        = 1'b0;
      pow_init     = 1'b0;
      pp_in        = pp_ff;
      w_in         = w_ff;
      ax_in        = ax_ff;
      ay_in        = ay_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      sum_x_in     = sum_x_ff;
      sum_y_in     = sum_y_ff;
      scl_x_in     = scl_x_ff;
      scl_y_in     = scl_y_ff;
      sc_in        = sc_ff;
      rnd_x_in     = rnd_x_ff;
      rnd_y_in     = rnd_y_ff;
      j_in         = j_ff;
      d_in         = d_ff;
      q_in         = q_ff;
      r_in         = r_ff;
      rstep_in     = rstep_ff;
      div_start    = 1'b0;
      rsp_valid_in = (rsp_valid_ff && rsp_tready) ? 1'b0 : rsp_valid_ff;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      idx_in       = idx_ff;
      last_in      = last_ff;
      emit         = 1'b0;
      term_s       = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept && req_cmd != CMD_WRITE) begin
               cmd_in   = req_cmd;
               u_in     = (u_raw > ONE_Q16) ? ONE_Q16 : u_raw;
               m_in     = (req_cmd == CMD_DERIV) ? 4'(np_clamped - 5'd2)
                                                 : 4'(np_clamped - 5'd1);
               nmul_in  = (req_cmd == CMD_DERIV) ? 4'(np_clamped - 5'd1) : 4'd1;
               j_in     = '0;
               d_in     = 6'(cnt_clamped - 7'd1);
               if (req_cmd == CMD_SAMPLE) begin
                  state_in = ST_DIV;
               end else begin
                  state_in = ST_PU;
               end
               div_start  = 1'b0;
               i_in       = '0;
               k_in       = 4'd1;
               sum_x_in   = '0;
               sum_y_in   = '0;
               pu_last_in = ONE_Q30;
               pv_last_in = ONE_Q30;
               pow_init   = 1'b1;
               if (req_cmd != CMD_SAMPLE && m_in == 4'd0) begin
                  state_in = ST_WA;
               end
            end
         end
         ST_DIV: begin
            // The divider is started on entry; its quotient and remainder are taken when it reports done.
            if (div_st.done) begin
               q_in     = div_st.quotient;
               rstep_in = div_st.remainder;
               u_in     = '0;
               r_in     = {1'b0, d_ff};
               state_in = (m_ff == 4'd0) ? ST_WA : ST_PU;
            end
         end
         ST_PU: state_in = ST_PUW;
         ST_PUW: begin
            pu_last_in = 31'((prod + 64'd32768) >> 16);
            pu_we      = 1'b1;
            state_in   = ST_PV;
         end
         ST_PV: state_in = ST_PVW;
         ST_PVW: begin
            pv_last_in = 31'((prod + 64'd32768) >> 16);
            pv_we      = 1'b1;
            if (k_ff == m_ff) begin
               state_in = ST_WA;
            end else begin
               k_in     = k_ff + 4'd1;
               state_in = ST_PU;
            end
         end
         ST_WA: state_in = ST_WB;
         ST_WB: begin
            pp_in    = 31'((prod + 64'h2000_0000) >> 30);
            sx_in    = dx[32];
            sy_in    = dy[32];
            ax_in    = dx[32] ? 33'(-dx) : 33'(dx);
            ay_in    = dy[32] ? 33'(-dy) : 33'(dy);
            state_in = ST_WC;
         end
         ST_WC: state_in = ST_WD;
         ST_WD: begin
            w_in     = (prod > {33'd0, ONE_Q30}) ? ONE_Q30 : prod[30:0];
            state_in = ST_MX;
         end
         ST_MX: state_in = ST_MY;
         ST_MY: begin
            term_s   = sx_ff ? -$signed({6'd0, term_mag}) : $signed({6'd0, term_mag});
            sum_x_in = sum_x_ff + term_s;
            state_in = ST_AY;
         end
         ST_AY: begin
            term_s   = sy_ff ? -$signed({6'd0, term_mag}) : $signed({6'd0, term_mag});
            sum_y_in = sum_y_ff + term_s;
            if (i_ff == m_ff) begin
               scl_x_in = '0;
               scl_y_in = '0;
               sc_in    = '0;
               state_in = ST_SCL;
            end else begin
               i_in     = i_ff + 4'd1;
               state_in = ST_WA;
            end
         end
         ST_SCL: begin
            // Multiply the sums by the derivative factor (1 for a point or sample), one bit a cycle.
            if (nmul_ff[sc_ff]) begin
               scl_x_in = scl_x_ff + ($signed({{4{sum_x_ff[55]}}, sum_x_ff}) <<< sc_ff);
               scl_y_in = scl_y_ff + ($signed({{4{sum_y_ff[55]}}, sum_y_ff}) <<< sc_ff);
            end
            sc_in = sc_ff + 2'd1;
            if (sc_ff == 2'd3) begin
               state_in = ST_RND;
            end
         end
         ST_RND: begin
            rnd_x_in = scl_x_ff[59] ? -$signed({1'b0, rr_x}) : $signed({1'b0, rr_x});
            rnd_y_in = scl_y_ff[59] ? -$signed({1'b0, rr_y}) : $signed({1'b0, rr_y});
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               emit         = 1'b1;
               rsp_valid_in = 1'b1;
               out_x_in = (rnd_x_ff > 45'sh7FFF_FFFF) ? 32'h7FFF_FFFF :
                          (rnd_x_ff < -45'sh8000_0000) ? 32'h8000_0000 : rnd_x_ff[31:0];
               out_y_in = (rnd_y_ff > 45'sh7FFF_FFFF) ? 32'h7FFF_FFFF :
                          (rnd_y_ff < -45'sh8000_0000) ? 32'h8000_0000 : rnd_y_ff[31:0];
               if (cmd_ff == CMD_SAMPLE) begin
                  idx_in  = j_ff;
                  last_in = (j_ff == d_ff);
               end else begin
                  idx_in  = '0;
                  last_in = 1'b1;
               end
               if (cmd_ff == CMD_SAMPLE && j_ff != d_ff) begin
                  // Step t by 1/d with an exact running remainder.
                  j_in = j_ff + 6'd1;
                  if (r_sum >= {1'b0, d_ff, 1'b0}) begin
                     r_in = 7'(r_sum - {1'b0, d_ff, 1'b0});
                     u_in = u_ff + q_ff + 17'd1;
                  end else begin
                     r_in = r_sum[6:0];
                     u_in = u_ff + q_ff;
                  end
                  i_in       = '0;
                  k_in       = 4'd1;
                  sum_x_in   = '0;
                  sum_y_in   = '0;
                  pu_last_in = ONE_Q30;
                  pv_last_in = ONE_Q30;
                  state_in   = (m_ff == 4'd0) ? ST_WA : ST_PU;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (state_ff != ST_DIV && state_in == ST_DIV) begin
         div_start = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (pow_init) begin
         pow_u[0] <= ONE_Q30;
         pow_v[0] <= ONE_Q30;
      end
      if (pu_we) begin
         pow_u[k_ff] <= pu_last_in;
      end
      if (pv_we) begin
         pow_v[k_ff] <= pv_last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         np_ff        <= 5'd4;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         np_ff        <= np_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff     <= cmd_in;
      u_ff       <= u_in;
      m_ff       <= m_in;
      nmul_ff    <= nmul_in;
      i_ff       <= i_in;
      k_ff       <= k_in;
      pu_last_ff <= pu_last_in;
      pv_last_ff <= pv_last_in;
      pp_ff      <= pp_in;
      w_ff       <= w_in;
      ax_ff      <= ax_in;
      ay_ff      <= ay_in;
      sx_ff      <= sx_in;
      sy_ff      <= sy_in;
      sum_x_ff   <= sum_x_in;
      sum_y_ff   <= sum_y_in;
      scl_x_ff   <= scl_x_in;
      scl_y_ff   <= scl_y_in;
      sc_ff      <= sc_in;
      rnd_x_ff   <= rnd_x_in;
      rnd_y_ff   <= rnd_y_in;
      j_ff       <= j_in;
      d_ff       <= d_in;
      q_ff       <= q_in;
      r_ff       <= r_in;
      rstep_ff   <= rstep_in;
      out_x_ff   <= out_x_in;
      out_y_ff   <= out_y_in;
      idx_ff     <= idx_in;
      last_ff    <= last_in;
   end

   `BCE_ASSERT_NEXT(a_busy_after_eval, clock, reset, accept && req_cmd != CMD_WRITE, !req_tready)
   `BCE_ASSERT_NOW(a_weight_clamped, clock, reset, state_ff == ST_MX, w_ff <= ONE_Q30)
   `BCE_ASSERT_NOW(a_fin_after_all_terms, clock, reset, state_ff == ST_FIN, i_ff == m_ff)
   `BCE_ASSERT_NOW(a_emit_slot_free, clock, reset, emit, !rsp_valid_ff || rsp_tready)
endmodule
